[design/pwbs_pkg.sv]
// shared types and constants of the pulse width bit serializer
`default_nettype none

package pwbs_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_START = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_ONE_HIGH  = 2'd0,
    REG_ZERO_HIGH = 2'd1,
    REG_PERIOD    = 2'd2,
    REG_PAUSE     = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_BITS  = 3'b010,
    PH_PAUSE = 3'b100
  } phase_e;

  localparam int unsigned HighW  = 10;
  localparam int unsigned PauseW = 21;
  localparam int unsigned CfgW   = 21;

  localparam logic [HighW-1:0]  OneHighRst  = 10'd200;
  localparam logic [HighW-1:0]  ZeroHighRst = 10'd100;
  localparam logic [HighW-1:0]  PeriodRst   = 10'd300;
  localparam logic [PauseW-1:0] PauseRst    = 21'd1200000;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
    logic rejected;
  } res_t;

endpackage

`default_nettype wire

[design/pwbs_if.sv]
// handshake channels of the pulse width bit serializer
`default_nettype none

interface pwbs_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] byte_value;
  logic [3:0] byte_index;

  modport source (output valid, output opcode, output byte_value, output byte_index,
                  input ready);
  modport sink   (input valid, input opcode, input byte_value, input byte_index,
                  output ready);
endinterface

interface pwbs_res_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic frame_done;
  logic rejected;

  modport source (output valid, output line_level, output busy_res, output frame_done,
                  output rejected, input ready);
  modport sink   (input valid, input line_level, input busy_res, input frame_done,
                  input rejected, output ready);
endinterface

interface pwbs_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                waddr;
  logic [pwbs_pkg::CfgW-1:0] wdata;

  modport source (output valid, output waddr, output wdata, input ready);
  modport sink   (input valid, input waddr, input wdata, output ready);
endinterface

`default_nettype wire

[design/pwbs_ram.sv]
// generic single write, single read ram with registered read data
`default_nettype none

module pwbs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[design/pwbs_frame_store.sv]
// frame byte store: ram plus per-byte valid bits and write-to-read forwarding
`default_nettype none

module pwbs_frame_store #(
  parameter int unsigned Bytes = 12,
  localparam int unsigned AddrW = (Bytes > 1) ? $clog2(Bytes) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [7:0]       wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [7:0]       rdata_o
);

  logic [Bytes-1:0] vld_q;
  logic             rd_vld_q;
  logic             fwd_hit_q;
  logic [7:0]       fwd_data_q;
  logic [7:0]       ram_rdata;

  pwbs_ram #(
    .Width(8),
    .Depth(Bytes)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we_i),
    .waddr_i(waddr_i),
    .wdata_i(wdata_i),
    .raddr_i(raddr_i),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rd_vld_q  <= vld_q[raddr_i];
      fwd_hit_q <= we_i && (waddr_i == raddr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= wdata_i;
  end

  // never written bytes read as zero
  always_comb begin
    if (fwd_hit_q) begin
      rdata_o = fwd_data_q;
    end else if (rd_vld_q) begin
      rdata_o = ram_rdata;
    end else begin
      rdata_o = 8'd0;
    end
  end

endmodule

`default_nettype wire

[design/pulse_width_bit_serializer.sv]
// top level of the pulse width bit serializer
`default_nettype none

// Pulse width LED serializer. Each input item is one tick (opcode 0), a frame byte
// load (opcode 1) or a frame start (opcode 2), and gives exactly one result item.
// An item can be taken every clock cycle; its result sits in the output register
// from the next cycle on. A new item is taken in any cycle where that register is
// empty or its result leaves, so a stalled result holds the input. The frame
// sits in a byte RAM with registered read data; the RAM is always addressed with
// the byte of the next bit position so the current byte is ready when a tick needs
// it, and a load to that byte is forwarded. Per-byte valid bits make the frame read
// as zeros after reset, so no clearing pass is needed. Loads and starts are rejected
// while a frame or its pause is in progress. Configuration writes are taken at once.
module pulse_width_bit_serializer #(
  parameter int unsigned FRAME_BITS = 96
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pwbs_item_if.sink item_i,
  pwbs_res_if.source res_o,
  pwbs_cfg_if.sink  cfg_i
);
  import pwbs_pkg::*;

  localparam int unsigned Bytes = (FRAME_BITS + 7) / 8;
  localparam int unsigned AddrW = (Bytes > 1) ? $clog2(Bytes) : 1;
  localparam int unsigned PosW  = $clog2(FRAME_BITS);
  localparam logic [PosW-1:0] LastPos = PosW'(FRAME_BITS - 1);

  // configuration registers
  logic [HighW-1:0]  one_high_q, zero_high_q, period_q;
  logic [PauseW-1:0] pause_q;

  // sequencer state
  phase_e            phase_q, phase_d;
  logic [PosW-1:0]   bitpos_q, bitpos_d;
  logic [PauseW-1:0] tick_q, tick_d;

  logic              res_vld_q;
  res_t              res_q, res_d;

  logic              accept;
  logic              busy;
  logic              mem_we;
  logic [AddrW-1:0]  mem_raddr;
  logic [7:0]        cur_byte;
  logic              cur_bit;
  logic [HighW-1:0]  high_ticks;
  logic [HighW-1:0]  per_ticks;
  logic [PauseW-1:0] pz_ticks;
  logic [PauseW:0]   tick_inc;
  logic              per_end, pause_end;
  logic              done, rej;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_high_q  <= OneHighRst;
      zero_high_q <= ZeroHighRst;
      period_q    <= PeriodRst;
      pause_q     <= PauseRst;
    end else if (cfg_i.valid) begin
      unique case (reg_e'(cfg_i.waddr))
        REG_ONE_HIGH:  one_high_q  <= cfg_i.wdata[HighW-1:0];
        REG_ZERO_HIGH: zero_high_q <= cfg_i.wdata[HighW-1:0];
        REG_PERIOD:    period_q    <= cfg_i.wdata[HighW-1:0];
        REG_PAUSE:     pause_q     <= cfg_i.wdata[PauseW-1:0];
        default:       one_high_q  <= one_high_q;
      endcase
    end
  end

  assign item_i.ready = !res_vld_q || res_o.ready;
  assign accept       = item_i.valid && item_i.ready;
  assign busy         = (phase_q != PH_IDLE);

  assign mem_we = accept && (op_e'(item_i.opcode) == OP_LOAD) && !busy &&
                  (32'(item_i.byte_index) < Bytes);
  // prefetch the byte of the position the sequencer moves to
  assign mem_raddr = AddrW'(bitpos_d >> 3);

  pwbs_frame_store #(
    .Bytes(Bytes)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (mem_we),
    .waddr_i(AddrW'(item_i.byte_index)),
    .wdata_i(item_i.byte_value),
    .raddr_i(mem_raddr),
    .rdata_o(cur_byte)
  );

  // msb first within a byte
  assign cur_bit    = cur_byte[3'd7 - bitpos_q[2:0]];
  assign high_ticks = cur_bit ? one_high_q : zero_high_q;
  assign per_ticks  = (period_q == '0) ? HighW'(1) : period_q;
  assign pz_ticks   = (pause_q == '0) ? PauseW'(1) : pause_q;
  assign tick_inc   = {1'b0, tick_q} + (PauseW + 1)'(1);
  assign per_end    = tick_inc >= (PauseW + 1)'(per_ticks);
  assign pause_end  = tick_inc >= {1'b0, pz_ticks};

  always_comb begin
    phase_d  = phase_q;
    bitpos_d = bitpos_q;
    tick_d   = tick_q;
    done     = 1'b0;
    rej      = 1'b0;
    if (accept) begin
      unique case (item_i.opcode)
        OP_TICK: begin
          unique case (phase_q)
            PH_BITS: begin
              if (per_end) begin
                tick_d = '0;
                if (bitpos_q == LastPos) begin
                  bitpos_d = '0;
                  phase_d  = PH_PAUSE;
                end else begin
                  bitpos_d = bitpos_q + PosW'(1);
                end
              end else begin
                tick_d = tick_inc[PauseW-1:0];
              end
            end
            PH_PAUSE: begin
              if (pause_end) begin
                tick_d  = '0;
                phase_d = PH_IDLE;
                done    = 1'b1;
              end else begin
                tick_d = tick_inc[PauseW-1:0];
              end
            end
            default: phase_d = PH_IDLE;
          endcase
        end
        OP_LOAD: rej = busy;
        OP_START: begin
          if (busy) begin
            rej = 1'b1;
          end else begin
            phase_d  = PH_BITS;
            bitpos_d = '0;
            tick_d   = '0;
          end
        end
        default: rej = 1'b0;
      endcase
    end
  end

  always_comb begin
    res_d.line_level = (phase_q == PH_BITS) && (tick_q < PauseW'(high_ticks));
    res_d.busy_res   = (phase_d != PH_IDLE);
    res_d.frame_done = done;
    res_d.rejected   = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      bitpos_q  <= '0;
      tick_q    <= '0;
      res_vld_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      bitpos_q <= bitpos_d;
      tick_q   <= tick_d;
      if (item_i.ready) begin
        res_vld_q <= accept;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid      = res_vld_q;
  assign res_o.line_level = res_q.line_level;
  assign res_o.busy_res   = res_q.busy_res;
  assign res_o.frame_done = res_q.frame_done;
  assign res_o.rejected   = res_q.rejected;

endmodule

`default_nettype wire
